### design/bba_pkg.sv
package bba_pkg;

   localparam int ADDR_W    = 48;
   localparam int SIZE_W    = 32;
   localparam int NEED_W    = 34;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BYTES = 1'b1;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [SIZE_W-1:0] POOL_BYTES_RESET = 32'd65536;

   typedef enum logic [1:0] {
      NODE_FREE  = 2'd0,
      NODE_SPLIT = 2'd1,
      NODE_USED  = 2'd2
   } node_state_type;

   typedef enum logic [1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_NO_SPACE = 2'd1,
      STATUS_BAD_FREE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_AREAD,
      S_AEVAL,
      S_BACK,
      S_FREAD,
      S_FEVAL,
      S_MREAD,
      S_MEVAL,
      S_DONE
   } fsm_type;

endpackage

### design/bba_if.sv
interface bba_req_if;
   import bba_pkg::*;
   logic              valid;
   logic              ready;
   logic              kind;
   logic [SIZE_W-1:0] request_bytes;
   logic [ADDR_W-1:0] block_address;
   modport source (output valid, output kind, output request_bytes, output block_address,
                   input ready);
   modport sink (input valid, input kind, input request_bytes, input block_address,
                 output ready);
endinterface

interface bba_rsp_if;
   import bba_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [ADDR_W-1:0] result_address;
   modport source (output valid, output status, output result_address, input ready);
   modport sink (input valid, input status, input result_address, output ready);
endinterface

### design/buddy_block_allocator_core.sv
// Channel   Direction  Words
// req_ch    in         kind, request_bytes, block_address
// rsp_ch    out        status, result_address
// csr_*     in         pool_base (index 0), pool_bytes (index 1)
//
// One request is in flight at a time; the node store is a RAM with a registered read port
// and a separate write port. An allocate reads and evaluates each node visited, steps back
// in S_BACK and posts the result. The user must keep LINE_BYTES a power of two; the block
// does not enforce it. A free reads each level visited, checks each merge, then posts.
// After reset or a pool_bytes write, the store is cleared before a request is taken.
// A finished word waits in the output register while the next request is taken.
module buddy_block_allocator_core #(
   parameter int MAX_LEVELS = 10,
   parameter int LINE_BYTES = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   bba_req_if.sink                          req_ch,
   bba_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [bba_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bba_pkg::ADDR_W-1:0]       csr_wdata
);
   import bba_pkg::*;

   localparam int NODE_COUNT = (1 << (MAX_LEVELS + 1)) - 1;
   localparam int IDX_W      = MAX_LEVELS + 1;
   localparam int LVL_W      = $clog2(MAX_LEVELS + 1);
   localparam int DVD_W      = SIZE_W + 1;
   localparam int LINE_SH    = $clog2(LINE_BYTES);

   node_state_type node_mem [NODE_COUNT];

   fsm_type           state_ff, state_in;
   logic [ADDR_W-1:0] pool_base_ff, pool_base_in;
   logic [SIZE_W-1:0] pool_bytes_ff, pool_bytes_in;
   logic              clearing_ff, clearing_in;
   logic [IDX_W-1:0]  clr_idx_ff, clr_idx_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [ADDR_W-1:0] target_ff, target_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [LVL_W-1:0]  lvl_ff, lvl_in;
   logic [SIZE_W-1:0] off_ff, off_in;
   status_type        res_status_ff, res_status_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   node_state_type    rd_data_ff;

   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   node_state_type    mem_wdata;
   logic [IDX_W-1:0]  rd_addr;
   logic [SIZE_W-1:0] sz;
   logic [SIZE_W-1:0] half;
   logic              leaf;
   logic              fits;
   logic [IDX_W-1:0]  left_idx;
   logic [IDX_W-1:0]  parent_idx;
   logic [IDX_W-1:0]  buddy_idx;
   logic [DVD_W-1:0]  round_up;
   logic              req_ready;

   assign sz         = pool_bytes_ff >> lvl_ff;
   assign half       = sz >> 1;
   assign leaf       = (lvl_ff == LVL_W'(MAX_LEVELS)) || (NEED_W'(half) < need_ff);
   assign fits       = NEED_W'(sz) >= need_ff;
   assign left_idx   = (idx_ff << 1) + IDX_W'(1);
   assign parent_idx = (idx_ff - IDX_W'(1)) >> 1;
   assign buddy_idx  = idx_ff[0] ? idx_ff + IDX_W'(1) : idx_ff - IDX_W'(1);
   assign rd_addr    = (state_ff == S_MREAD) ? buddy_idx : idx_ff;
   assign round_up   = DVD_W'(req_ch.request_bytes) + DVD_W'(LINE_BYTES - 1);
   assign req_ready  = (state_ff == S_IDLE) && !clearing_ff;

   assign req_ch.ready          = req_ready;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.result_address = rsp_addr_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= node_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pool_base_ff  <= '0;
         pool_bytes_ff <= POOL_BYTES_RESET;
         clearing_ff   <= 1'b1;
         clr_idx_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pool_base_ff  <= pool_base_in;
         pool_bytes_ff <= pool_bytes_in;
         clearing_ff   <= clearing_in;
         clr_idx_ff    <= clr_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      need_ff       <= need_in;
      target_ff     <= target_in;
      idx_ff        <= idx_in;
      lvl_ff        <= lvl_in;
      off_ff        <= off_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   always_comb begin
      state_in      = state_ff;
      pool_base_in  = pool_base_ff;
      pool_bytes_in = pool_bytes_ff;
      clearing_in   = clearing_ff;
      clr_idx_in    = clr_idx_ff;
      need_in       = need_ff;
      target_in     = target_ff;
      idx_in        = idx_ff;
      lvl_in        = lvl_ff;
      off_in        = off_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = NODE_FREE;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid && req_ready) begin
               idx_in = '0;
               lvl_in = '0;
               off_in = '0;
               if (req_ch.kind == KIND_ALLOC) begin
                  need_in  = (NEED_W'(round_up >> LINE_SH) + NEED_W'(1)) << LINE_SH;
                  state_in = S_AREAD;
               end else begin
                  target_in = req_ch.block_address - ADDR_W'(LINE_BYTES) - pool_base_ff;
                  state_in  = S_FREAD;
               end
            end
         end
         S_AREAD: begin
            state_in = S_AEVAL;
         end
         S_AEVAL: begin
            if (leaf) begin
               if (rd_data_ff == NODE_FREE && fits) begin
                  mem_we        = 1'b1;
                  mem_wdata     = NODE_USED;
                  res_status_in = STATUS_DONE;
                  res_addr_in   = pool_base_ff + ADDR_W'(off_ff) + ADDR_W'(LINE_BYTES);
                  state_in      = S_DONE;
               end else begin
                  state_in = S_BACK;
               end
            end else if (rd_data_ff == NODE_USED) begin
               state_in = S_BACK;
            end else begin
               if (rd_data_ff == NODE_FREE) begin
                  mem_we    = 1'b1;
                  mem_wdata = NODE_SPLIT;
               end
               idx_in   = left_idx;
               lvl_in   = lvl_ff + LVL_W'(1);
               state_in = S_AREAD;
            end
         end
         S_BACK: begin
            if (idx_ff == '0) begin
               res_status_in = STATUS_NO_SPACE;
               res_addr_in   = '0;
               state_in      = S_DONE;
            end else if (idx_ff[0]) begin
               idx_in   = idx_ff + IDX_W'(1);
               off_in   = off_ff + sz;
               state_in = S_AREAD;
            end else begin
               idx_in = parent_idx;
               lvl_in = lvl_ff - LVL_W'(1);
               off_in = off_ff - sz;
            end
         end
         S_FREAD: begin
            state_in = S_FEVAL;
         end
         S_FEVAL: begin
            res_addr_in = '0;
            if (rd_data_ff == NODE_USED) begin
               if (ADDR_W'(off_ff) == target_ff) begin
                  mem_we    = 1'b1;
                  mem_wdata = NODE_FREE;
                  res_status_in = STATUS_DONE;
                  state_in  = (idx_ff == '0) ? S_DONE : S_MREAD;
               end else begin
                  res_status_in = STATUS_BAD_FREE;
                  state_in      = S_DONE;
               end
            end else if (rd_data_ff != NODE_SPLIT || lvl_ff == LVL_W'(MAX_LEVELS)) begin
               res_status_in = STATUS_BAD_FREE;
               state_in      = S_DONE;
            end else begin
               lvl_in   = lvl_ff + LVL_W'(1);
               state_in = S_FREAD;
               if (target_ff >= ADDR_W'(off_ff) + ADDR_W'(half)) begin
                  idx_in = left_idx + IDX_W'(1);
                  off_in = off_ff + half;
               end else begin
                  idx_in = left_idx;
               end
            end
         end
         S_MREAD: begin
            state_in = S_MEVAL;
         end
         S_MEVAL: begin
            res_status_in = STATUS_DONE;
            res_addr_in   = '0;
            if (rd_data_ff == NODE_FREE) begin
               mem_we    = 1'b1;
               mem_waddr = parent_idx;
               mem_wdata = NODE_FREE;
               idx_in    = parent_idx;
               state_in  = (parent_idx == '0) ? S_DONE : S_MREAD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (clearing_ff) begin
         mem_we     = 1'b1;
         mem_waddr  = clr_idx_ff;
         mem_wdata  = NODE_FREE;
         clr_idx_in = clr_idx_ff + IDX_W'(1);
         if (clr_idx_ff == IDX_W'(NODE_COUNT - 1)) begin
            clearing_in = 1'b0;
         end
      end

      if (csr_we) begin
         unique case (csr_index)
            CSR_POOL_BASE: begin
               pool_base_in = csr_wdata;
            end
            CSR_POOL_BYTES: begin
               pool_bytes_in = csr_wdata[SIZE_W-1:0];
               clearing_in   = 1'b1;
               clr_idx_in    = '0;
            end
            default: begin
               pool_base_in = pool_base_ff;
            end
         endcase
      end
   end

endmodule

### design/bba_checker.sv
module bba_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [47:0] rsp_result_address,
   input logic        csr_we,
   input logic        csr_index
);
   import bba_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_result_address))
      else $error("Stalled response word changed.");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STATUS_DONE || rsp_status == STATUS_NO_SPACE
         || rsp_status == STATUS_BAD_FREE)
      else $error("Response status has no meaning.");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_DONE |-> rsp_result_address == '0)
      else $error("Failed request returned a nonzero address.");

   a_reset_clear: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("Request taken before the node store was cleared.");

   a_pool_clear: assert property (@(posedge clock) disable iff (reset)
      csr_we && csr_index == CSR_POOL_BYTES |=> !req_ready)
      else $error("Request taken while the node store is being cleared.");

endmodule

bind buddy_block_allocator_core bba_checker u_bba_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_status         (rsp_ch.status),
   .rsp_result_address (rsp_ch.result_address),
   .csr_we             (csr_we),
   .csr_index          (csr_index)
);

### dv/buddy_block_allocator_core_test.sv
`timescale 1ns / 1ps

module buddy_block_allocator_core_test;
   import bba_pkg::*;

   localparam int MAX_LEVELS = 10;
   localparam int LINE_BYTES = 64;
   localparam int NODE_COUNT = (1 << (MAX_LEVELS + 1)) - 1;
   localparam int IDLE_LIMIT = 40000;
   localparam int LONG_HOLD  = 1500;

   typedef struct packed {
      logic              kind;
      logic [SIZE_W-1:0] request_bytes;
      logic [ADDR_W-1:0] block_address;
   } alloc_req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] result_address;
   } alloc_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_POOL_BASE;
   logic [ADDR_W-1:0] csr_wdata = '0;

   bba_req_if req_bus ();
   bba_rsp_if rsp_bus ();

   buddy_block_allocator_core #(
      .MAX_LEVELS(MAX_LEVELS),
      .LINE_BYTES(LINE_BYTES)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   node_state_type tree_state [0:NODE_COUNT-1];
   logic [ADDR_W-1:0] model_base;
   logic [63:0] model_bytes;
   logic [ADDR_W-1:0] live_blocks [$];

   alloc_req_type req_backlog [$];
   alloc_reply_type expected_replies [$];
   int fail_count = 0;
   int req_gap = 0;
   int rsp_stall = 0;
   int hold_asks = 0;
   int hold_served = 0;
   int idle_cycles = 0;

   task automatic report_mismatch(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
      $display("%0t: %s mismatch: got %h, want %h", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 20);
      return $urandom_range(50, 200);
   endfunction

   function automatic void clear_tree();
      for (int i = 0; i < NODE_COUNT; i++) tree_state[i] = NODE_FREE;
   endfunction

   // Depth-first search, left child first, with an explicit stack per level.
   function automatic bit carve_block(input logic [63:0] need, output logic [63:0] hit);
      int idx [0:MAX_LEVELS+1];
      logic [63:0] off [0:MAX_LEVELS+1];
      logic [63:0] sz [0:MAX_LEVELS+1];
      int stage [0:MAX_LEVELS+1];
      int d;
      bit found;
      logic [63:0] half;
      d = 0;
      idx[0] = 0;
      off[0] = 0;
      sz[0] = model_bytes;
      stage[0] = 0;
      found = 0;
      hit = 0;
      while (d >= 0) begin
         if (stage[d] == 0) begin
            half = sz[d] >> 1;
            if (idx[d] >= NODE_COUNT) begin
               found = 0;
               d--;
            end else if (d >= MAX_LEVELS || half < need) begin
               found = 0;
               if (tree_state[idx[d]] == NODE_FREE && sz[d] >= need) begin
                  tree_state[idx[d]] = NODE_USED;
                  hit = off[d];
                  found = 1;
               end
               d--;
            end else if (tree_state[idx[d]] == NODE_USED) begin
               found = 0;
               d--;
            end else begin
               if (tree_state[idx[d]] == NODE_FREE) begin
                  tree_state[idx[d]] = NODE_SPLIT;
                  tree_state[2*idx[d]+1] = NODE_FREE;
                  tree_state[2*idx[d]+2] = NODE_FREE;
               end
               stage[d] = 1;
               idx[d+1] = 2*idx[d] + 1;
               off[d+1] = off[d];
               sz[d+1] = half;
               stage[d+1] = 0;
               d++;
            end
         end else if (stage[d] == 1) begin
            if (found) begin
               d--;
            end else begin
               stage[d] = 2;
               idx[d+1] = 2*idx[d] + 2;
               off[d+1] = off[d] + (sz[d] >> 1);
               sz[d+1] = sz[d] >> 1;
               stage[d+1] = 0;
               d++;
            end
         end else begin
            d--;
         end
      end
      return found;
   endfunction

   function automatic bit reclaim_block(input logic [ADDR_W-1:0] target);
      int idx;
      int lvl;
      int buddy;
      int parent;
      logic [63:0] off;
      logic [63:0] sz;
      logic [63:0] half;
      idx = 0;
      lvl = 0;
      off = 0;
      sz = model_bytes;
      forever begin
         if (tree_state[idx] == NODE_USED) begin
            if (off != {16'd0, target}) return 0;
            break;
         end
         if (tree_state[idx] != NODE_SPLIT || lvl >= MAX_LEVELS) return 0;
         half = sz >> 1;
         if ({16'd0, target} >= off + half) begin
            idx = 2*idx + 2;
            off = off + half;
         end else begin
            idx = 2*idx + 1;
         end
         sz = half;
         lvl++;
      end
      tree_state[idx] = NODE_FREE;
      while (idx != 0) begin
         buddy = (idx % 2 == 1) ? idx + 1 : idx - 1;
         parent = (idx - 1) / 2;
         if (tree_state[buddy] != NODE_FREE) break;
         tree_state[buddy] = NODE_FREE;
         tree_state[parent] = NODE_FREE;
         idx = parent;
      end
      return 1;
   endfunction

   function automatic alloc_reply_type serve_request(alloc_req_type it);
      alloc_reply_type rep;
      logic [63:0] lines;
      logic [63:0] need;
      logic [63:0] hit;
      logic [ADDR_W-1:0] target;
      rep.status = STATUS_DONE;
      rep.result_address = '0;
      if (it.kind == KIND_ALLOC) begin
         lines = ({32'd0, it.request_bytes} + 64'(LINE_BYTES - 1)) / 64'(LINE_BYTES);
         need = (lines + 64'd1) * 64'(LINE_BYTES);
         if (carve_block(need, hit)) begin
            rep.result_address = model_base + hit[ADDR_W-1:0] + ADDR_W'(LINE_BYTES);
            live_blocks.push_back(rep.result_address);
         end else begin
            rep.status = STATUS_NO_SPACE;
         end
      end else begin
         target = it.block_address - ADDR_W'(LINE_BYTES) - model_base;
         if (reclaim_block(target)) begin
            foreach (live_blocks[i]) begin
               if (live_blocks[i] == it.block_address) begin
                  live_blocks.delete(i);
                  break;
               end
            end
         end else begin
            rep.status = STATUS_BAD_FREE;
         end
      end
      return rep;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_replies.push_back(serve_request(req_backlog[0]));
            req_backlog.pop_front();
            req_gap = pick_gap();
         end
         if (!(req_bus.valid && !req_bus.ready)) begin
            if (req_gap > 0 || req_backlog.size() == 0) begin
               req_bus.valid <= 1'b0;
               if (req_gap > 0) req_gap--;
            end else begin
               req_bus.valid <= 1'b1;
               req_bus.kind <= req_backlog[0].kind;
               req_bus.request_bytes <= req_backlog[0].request_bytes;
               req_bus.block_address <= req_backlog[0].block_address;
            end
         end
      end
   end

   always @(posedge clock) begin
      alloc_reply_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_replies.size() == 0) begin
               report_mismatch("unexpected word", rsp_bus.result_address, '0);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_bus.status !== want.status)
                  report_mismatch("status", {46'd0, rsp_bus.status}, {46'd0, want.status});
               if (rsp_bus.result_address !== want.result_address)
                  report_mismatch("result_address", rsp_bus.result_address,
                                  want.result_address);
            end
         end
         if (hold_asks != hold_served) begin
            hold_served = hold_asks;
            rsp_stall = LONG_HOLD;
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_stall = pick_gap();
            rsp_bus.ready <= (rsp_stall == 0);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic queue_item(logic kind, logic [SIZE_W-1:0] nbytes, logic [ADDR_W-1:0] addr);
      alloc_req_type it;
      it.kind = kind;
      it.request_bytes = nbytes;
      it.block_address = addr;
      req_backlog.push_back(it);
   endtask

   task automatic drain();
      while (req_backlog.size() != 0 || expected_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] index, logic [ADDR_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      if (index == CSR_POOL_BASE) begin
         model_base = value;
      end else begin
         model_bytes = {32'd0, value[SIZE_W-1:0]};
         clear_tree();
         live_blocks.delete();
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_traffic(int count);
      logic [63:0] span;
      logic [ADDR_W-1:0] pick;
      int r;
      for (int n = 0; n < count; n++) begin
         while (req_backlog.size() >= 3) @(posedge clock);
         r = $urandom_range(0, 99);
         span = model_bytes;
         if (r < 55) begin
            r = $urandom_range(0, 99);
            if (r < 15) span = 64'($urandom_range(0, 200));
            else if (r < 65) span = 64'($urandom_range(0, 32'(span / 16)));
            else if (r < 90) span = 64'($urandom_range(0, 32'(span / 2)));
            else span = 64'($urandom);
            queue_item(KIND_ALLOC, span[SIZE_W-1:0], ADDR_W'({$urandom, $urandom}));
         end else if (r < 90 && live_blocks.size() != 0) begin
            pick = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
            queue_item(KIND_FREE, $urandom, pick);
         end else begin
            r = $urandom_range(0, 2);
            if (r == 0 || live_blocks.size() == 0) pick = ADDR_W'({$urandom, $urandom});
            else pick = live_blocks[$urandom_range(0, live_blocks.size() - 1)]
                        + ADDR_W'($urandom_range(1, 2 * LINE_BYTES));
            queue_item(KIND_FREE, $urandom, pick);
         end
      end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_ALLOC;
      req_bus.request_bytes = '0;
      req_bus.block_address = '0;
      rsp_bus.ready = 1'b0;
      model_base = '0;
      model_bytes = {32'd0, POOL_BYTES_RESET};
      clear_tree();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      queue_item(KIND_ALLOC, 32'd0, '0);
      queue_item(KIND_ALLOC, 32'd1, '1);
      queue_item(KIND_ALLOC, 32'd64, '0);
      queue_item(KIND_ALLOC, 32'd65, '0);
      queue_item(KIND_ALLOC, 32'hFFFF_FFFF, '0);
      queue_item(KIND_ALLOC, 32'd20000, '0);
      drain();
      queue_item(KIND_FREE, '1, live_blocks[0]);
      queue_item(KIND_FREE, '0, live_blocks[0]);
      queue_item(KIND_FREE, '0, live_blocks[1] + 48'd1);
      queue_item(KIND_FREE, '0, 48'hFFFF_FFFF_FFFF);
      queue_item(KIND_FREE, '0, 48'h0);
      queue_item(KIND_FREE, '0, live_blocks[1]);
      queue_item(KIND_FREE, '0, live_blocks[2]);
      queue_item(KIND_FREE, '0, live_blocks[3]);
      queue_item(KIND_FREE, '0, live_blocks[4]);
      drain();
      queue_item(KIND_ALLOC, 32'd65472, '0);
      queue_item(KIND_ALLOC, 32'd0, '0);
      drain();
      queue_item(KIND_FREE, '0, live_blocks[0]);
      queue_item(KIND_ALLOC, 32'd65473, '0);
      drain();

      hold_asks++;
      random_traffic(260);
      drain();
      repeat (50) @(posedge clock);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_csr(CSR_POOL_BASE, 48'hFFFF_FFFF_FFC0);
               write_csr(CSR_POOL_BYTES, 48'd65536);
            end
            1: begin
               write_csr(CSR_POOL_BASE, ADDR_W'({$urandom, $urandom}));
               write_csr(CSR_POOL_BYTES, 48'd0);
            end
            2: begin
               write_csr(CSR_POOL_BASE, 48'h0);
               write_csr(CSR_POOL_BYTES, 48'h0000_FFFF_FFFF);
            end
            3: begin
               write_csr(CSR_POOL_BASE, 48'hFFFF_FFFF_FF00);
               write_csr(CSR_POOL_BYTES, {16'hA5A5, 32'd100});
            end
            4: begin
               write_csr(CSR_POOL_BASE, ADDR_W'({$urandom, $urandom}));
               write_csr(CSR_POOL_BYTES, 48'd131072);
            end
            default: begin
               write_csr(CSR_POOL_BASE, 48'hFFFF_FFFF_FFFF);
               write_csr(CSR_POOL_BYTES, 48'd777777);
            end
         endcase
         if (phase == 4) hold_asks++;
         random_traffic(260);
         drain();
         repeat (50) @(posedge clock);
      end

      drain();
      repeat (200) @(posedge clock);
      if (fail_count == 0 && expected_replies.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
